### sv/i2cms_pkg.sv
// ----------------------------------------------------------------------------
// i2cms_pkg
// Shared types and constants for the I2C master bit sequencer.
// ----------------------------------------------------------------------------
package i2cms_pkg;

   localparam int CMD_W   = 2;
   localparam int BYTE_W  = 8;
   localparam int PHASE_W = 5;

   typedef enum logic [CMD_W-1:0] {
      CMD_START = 2'd0,
      CMD_STOP  = 2'd1,
      CMD_WRITE = 2'd2,
      CMD_READ  = 2'd3
   } cmd_type;

   // action codes carried by req_action
   localparam logic ACT_TICK = 1'b0;
   localparam logic ACT_LOAD = 1'b1;

   // phase indexes for the end of the bit loops and the steps after it
   localparam logic [PHASE_W-1:0] PH_BITS_END = 5'd16;
   localparam logic [PHASE_W-1:0] PH_RELEASE  = 5'd17;
   localparam logic [PHASE_W-1:0] PH_ACK      = 5'd18;

endpackage

### sv/i2c_master_bit_sequencer.sv
// ----------------------------------------------------------------------------
// i2c_master_bit_sequencer
// Bit-banged I2C master: runs start, stop, byte write and byte read one delay
// phase per tick item and reports the SCL/SDA levels after every item.
// ----------------------------------------------------------------------------
// Every request item gives exactly one response item. A load item latches a
// command (ignored while a command is busy); each tick item runs one phase.
// Start and stop take 3 ticks, write 19 ticks, read 20 ticks; done_res pulses
// on the last one. For each item, the next state is
// computed from the request port and the phase registers and lands in the
// response register in the same clock, so one item per cycle is sustained.
// The only limit on rate is the response register: a request is taken when it
// is empty or being drained by rsp_ready in that cycle.
module i2c_master_bit_sequencer (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_action,
   input  logic [i2cms_pkg::CMD_W-1:0]   req_command,
   input  logic [i2cms_pkg::BYTE_W-1:0]  req_tx_byte,
   input  logic                          req_send_ack,
   input  logic                          req_sda_line,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic                          rsp_scl_level,
   output logic                          rsp_sda_level,
   output logic                          rsp_busy_res,
   output logic [i2cms_pkg::BYTE_W-1:0]  rsp_rx_byte,
   output logic                          rsp_ack_seen,
   output logic                          rsp_done_res
);
   import i2cms_pkg::*;

   logic [PHASE_W-1:0] phase_ff, phase_in;
   cmd_type            cmd_ff, cmd_in;
   logic [BYTE_W-1:0]  shift_ff, shift_in;
   logic [BYTE_W-1:0]  rx_last_ff, rx_last_in;
   logic               ack_choice_ff, ack_choice_in;
   logic               ack_flag_ff, ack_flag_in;
   logic               scl_ff, scl_in;
   logic               sda_ff, sda_in;
   logic               busy_ff, busy_in;
   logic               done_in;

   logic               rsp_valid_ff;
   logic               rsp_scl_ff, rsp_sda_ff, rsp_busy_ff, rsp_ack_ff, rsp_done_ff;
   logic [BYTE_W-1:0]  rsp_rx_ff;

   logic               accept;
   logic               fin;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   // phase step of the current command
   always_comb begin
      phase_in      = phase_ff;
      cmd_in        = cmd_ff;
      shift_in      = shift_ff;
      rx_last_in    = rx_last_ff;
      ack_choice_in = ack_choice_ff;
      ack_flag_in   = ack_flag_ff;
      scl_in        = scl_ff;
      sda_in        = sda_ff;
      busy_in       = busy_ff;
      fin           = 1'b0;
      done_in       = 1'b0;

      if (req_action == ACT_LOAD) begin
         if (!busy_ff) begin
            cmd_in        = cmd_type'(req_command);
            phase_in      = '0;
            ack_choice_in = req_send_ack;
            shift_in      = (cmd_type'(req_command) == CMD_WRITE) ? req_tx_byte : '0;
            busy_in       = 1'b1;
         end
      end else if (busy_ff) begin
         unique case (cmd_ff)
            CMD_START: begin
               if (phase_ff == 5'd0) begin
                  scl_in = 1'b1;
               end else if (phase_ff == 5'd1) begin
                  sda_in = 1'b1;
               end else begin
                  sda_in = 1'b0;
                  fin    = 1'b1;
               end
            end
            CMD_STOP: begin
               if (phase_ff == 5'd0) begin
                  sda_in = 1'b0;
               end else if (phase_ff == 5'd1) begin
                  scl_in = 1'b1;
               end else begin
                  sda_in = 1'b1;
                  fin    = 1'b1;
               end
            end
            CMD_WRITE: begin
               if (phase_ff < PH_BITS_END) begin
                  if (!phase_ff[0]) begin
                     scl_in = 1'b0;
                  end else begin
                     sda_in   = shift_ff[BYTE_W-1];
                     shift_in = {shift_ff[BYTE_W-2:0], 1'b0};
                     scl_in   = 1'b1;
                  end
               end else if (phase_ff == PH_BITS_END) begin
                  scl_in = 1'b0;
               end else if (phase_ff == PH_RELEASE) begin
                  sda_in = 1'b1;
               end else begin
                  scl_in      = 1'b1;
                  ack_flag_in = !req_sda_line;
                  fin         = 1'b1;
               end
            end
            CMD_READ: begin
               // sda is released before the first sample
               if (phase_ff == 5'd0) begin
                  scl_in = 1'b0;
                  sda_in = 1'b1;
               end else if (phase_ff <= PH_BITS_END) begin
                  if (phase_ff[0]) begin
                     scl_in   = 1'b1;
                     shift_in = {shift_ff[BYTE_W-2:0], req_sda_line};
                  end else begin
                     scl_in = 1'b0;
                  end
               end else if (phase_ff == PH_RELEASE) begin
                  scl_in = 1'b0;
               end else if (phase_ff == PH_ACK) begin
                  sda_in = !ack_choice_ff;
               end else begin
                  scl_in     = 1'b1;
                  rx_last_in = shift_ff;
                  fin        = 1'b1;
               end
            end
            default: begin
               fin = 1'b0;
            end
         endcase

         if (fin) begin
            busy_in  = 1'b0;
            phase_in = '0;
            done_in  = 1'b1;
         end else begin
            phase_in = phase_ff + 5'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= '0;
         cmd_ff        <= CMD_START;
         shift_ff      <= '0;
         rx_last_ff    <= '0;
         ack_choice_ff <= 1'b0;
         ack_flag_ff   <= 1'b0;
         scl_ff        <= 1'b1;
         sda_ff        <= 1'b1;
         busy_ff       <= 1'b0;
      end else if (accept) begin
         phase_ff      <= phase_in;
         cmd_ff        <= cmd_in;
         shift_ff      <= shift_in;
         rx_last_ff    <= rx_last_in;
         ack_choice_ff <= ack_choice_in;
         ack_flag_ff   <= ack_flag_in;
         scl_ff        <= scl_in;
         sda_ff        <= sda_in;
         busy_ff       <= busy_in;
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_scl_ff  <= scl_in;
         rsp_sda_ff  <= sda_in;
         rsp_busy_ff <= busy_in;
         rsp_rx_ff   <= rx_last_in;
         rsp_ack_ff  <= ack_flag_in;
         rsp_done_ff <= done_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_scl_level = rsp_scl_ff;
   assign rsp_sda_level = rsp_sda_ff;
   assign rsp_busy_res  = rsp_busy_ff;
   assign rsp_rx_byte   = rsp_rx_ff;
   assign rsp_ack_seen  = rsp_ack_ff;
   assign rsp_done_res  = rsp_done_ff;

   // a finishing transfer never reports busy
   a_done_not_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_done_ff |-> !rsp_busy_ff)
      else $error("done reported while busy");

   // phases only advance while a command runs
   a_phase_idle: assert property (@(posedge clock) disable iff (reset)
      phase_ff != '0 |-> busy_ff)
      else $error("phase count nonzero while idle");

   // a load while idle starts a command
   a_load_starts: assert property (@(posedge clock) disable iff (reset)
      accept && (req_action == ACT_LOAD) && !busy_ff |=> busy_ff && phase_ff == '0)
      else $error("load did not start command");

   // a load while busy leaves the pins alone
   a_busy_load_ignored: assert property (@(posedge clock) disable iff (reset)
      accept && (req_action == ACT_LOAD) && busy_ff
      |=> $stable(scl_ff) && $stable(sda_ff) && $stable(phase_ff))
      else $error("load while busy changed state");

endmodule

### bench/tb_i2c_master_bit_sequencer.sv
// ----------------------------------------------------------------------------
// tb_i2c_master_bit_sequencer
// Drives start, stop, byte write and byte read commands with their delay ticks
// into the I2C bit sequencer. A local pin-level model predicts every response,
// and the scoreboard compares each response field with the oldest prediction
// under random sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module tb_i2c_master_bit_sequencer;
   timeunit 1ns;
   timeprecision 1ps;

   import i2cms_pkg::*;

   localparam int CYCLE_LIMIT  = 400000;
   localparam int ITEMS_PER_RUN = 500;

   typedef struct packed {
      logic              action;
      cmd_type           command;
      logic [BYTE_W-1:0] tx_byte;
      logic              send_ack;
      logic              sda_line;
   } bus_op_type;

   typedef struct packed {
      logic              scl_level;
      logic              sda_level;
      logic              busy_res;
      logic [BYTE_W-1:0] rx_byte;
      logic              ack_seen;
      logic              done_res;
   } pin_report_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   logic              req_action = ACT_TICK;
   logic [CMD_W-1:0]  req_command = CMD_START;
   logic [BYTE_W-1:0] req_tx_byte = '0;
   logic              req_send_ack = 1'b0;
   logic              req_sda_line = 1'b1;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   logic              rsp_scl_level;
   logic              rsp_sda_level;
   logic              rsp_busy_res;
   logic [BYTE_W-1:0] rsp_rx_byte;
   logic              rsp_ack_seen;
   logic              rsp_done_res;

   bus_op_type     op_queue[$];
   pin_report_type expected_reports[$];
   bus_op_type     presented_op;
   bus_op_type     pick_op;
   int             send_idle_pct = 0;
   int             recv_idle_pct = 0;
   int             well_formed_count = 0;
   int             error_count = 0;
   int             cycle_count = 0;

   // pin model state
   logic [PHASE_W-1:0] phase_q;
   cmd_type            cmd_q;
   logic [BYTE_W-1:0]  shift_q;
   logic               ack_pick_q;
   logic               ack_got_q;
   logic               scl_q;
   logic               sda_q;
   logic               busy_q;
   logic [BYTE_W-1:0]  rx_hold_q;

   i2c_master_bit_sequencer dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_action    (req_action),
      .req_command   (req_command),
      .req_tx_byte   (req_tx_byte),
      .req_send_ack  (req_send_ack),
      .req_sda_line  (req_sda_line),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_scl_level (rsp_scl_level),
      .rsp_sda_level (rsp_sda_level),
      .rsp_busy_res  (rsp_busy_res),
      .rsp_rx_byte   (rsp_rx_byte),
      .rsp_ack_seen  (rsp_ack_seen),
      .rsp_done_res  (rsp_done_res)
   );

   always #1 clock = ~clock;

   function automatic void clear_pin_model();
      phase_q    = '0;
      cmd_q      = CMD_START;
      shift_q    = '0;
      ack_pick_q = 1'b0;
      ack_got_q  = 1'b0;
      scl_q      = 1'b1;
      sda_q      = 1'b1;
      busy_q     = 1'b0;
      rx_hold_q  = '0;
   endfunction

   // advances the pin model by one item and returns the levels it reports
   function automatic pin_report_type apply_bus_op(bus_op_type op);
      pin_report_type rep;
      logic           fin;
      fin = 1'b0;
      if (op.action == ACT_LOAD) begin
         if (!busy_q) begin
            cmd_q      = op.command;
            phase_q    = '0;
            ack_pick_q = op.send_ack;
            shift_q    = (op.command == CMD_WRITE) ? op.tx_byte : '0;
            busy_q     = 1'b1;
         end
      end else if (busy_q) begin
         case (cmd_q)
            CMD_START: begin
               if (phase_q == 0) scl_q = 1'b1;
               else if (phase_q == 1) sda_q = 1'b1;
               else begin
                  sda_q = 1'b0;
                  fin = 1'b1;
               end
            end
            CMD_STOP: begin
               if (phase_q == 0) sda_q = 1'b0;
               else if (phase_q == 1) scl_q = 1'b1;
               else begin
                  sda_q = 1'b1;
                  fin = 1'b1;
               end
            end
            CMD_WRITE: begin
               if (phase_q < PH_BITS_END) begin
                  if (!phase_q[0]) begin
                     scl_q = 1'b0;
                  end else begin
                     sda_q   = shift_q[BYTE_W-1];
                     shift_q = {shift_q[BYTE_W-2:0], 1'b0};
                     scl_q   = 1'b1;
                  end
               end else if (phase_q == PH_BITS_END) begin
                  scl_q = 1'b0;
               end else if (phase_q == PH_RELEASE) begin
                  sda_q = 1'b1;
               end else begin
                  scl_q     = 1'b1;
                  ack_got_q = ~op.sda_line;
                  fin       = 1'b1;
               end
            end
            default: begin
               // read lets go of sda before the first sample
               if (phase_q == 0) begin
                  scl_q = 1'b0;
                  sda_q = 1'b1;
               end else if (phase_q <= PH_BITS_END) begin
                  if (phase_q[0]) begin
                     scl_q   = 1'b1;
                     shift_q = {shift_q[BYTE_W-2:0], op.sda_line};
                  end else begin
                     scl_q = 1'b0;
                  end
               end else if (phase_q == PH_RELEASE) begin
                  scl_q = 1'b0;
               end else if (phase_q == PH_ACK) begin
                  sda_q = ~ack_pick_q;
               end else begin
                  scl_q     = 1'b1;
                  rx_hold_q = shift_q;
                  fin       = 1'b1;
               end
            end
         endcase
         phase_q = phase_q + 1'b1;
         if (fin) begin
            busy_q  = 1'b0;
            phase_q = '0;
         end
      end
      rep.scl_level = scl_q;
      rep.sda_level = sda_q;
      rep.busy_res  = busy_q;
      rep.rx_byte   = rx_hold_q;
      rep.ack_seen  = ack_got_q;
      rep.done_res  = fin;
      return rep;
   endfunction

   function automatic int ticks_for(cmd_type cmd);
      case (cmd) inside
         CMD_START, CMD_STOP: return 3;
         CMD_WRITE:           return 19;
         default:             return 20;
      endcase
   endfunction

   task automatic queue_load(cmd_type cmd, logic [BYTE_W-1:0] tx, logic sack);
      bus_op_type op;
      op.action   = ACT_LOAD;
      op.command  = cmd;
      op.tx_byte  = tx;
      op.send_ack = sack;
      op.sda_line = 1'($urandom);
      op_queue.push_back(op);
   endtask

   task automatic queue_ticks(int n);
      bus_op_type op;
      for (int i = 0; i < n; i++) begin
         op.action   = ACT_TICK;
         op.command  = cmd_type'($urandom_range(3));
         op.tx_byte  = BYTE_W'($urandom);
         op.send_ack = 1'($urandom);
         op.sda_line = 1'($urandom);
         op_queue.push_back(op);
      end
   endtask

   // one command with its ticks, sometimes with a stray load while it runs
   task automatic queue_transaction();
      cmd_type cmd;
      int      n;
      int      split;
      cmd = cmd_type'($urandom_range(3));
      n   = ticks_for(cmd);
      queue_load(cmd, BYTE_W'($urandom), 1'($urandom));
      if ($urandom_range(9) == 0) begin
         split = $urandom_range(n - 1);
         queue_ticks(split);
         queue_load(cmd_type'($urandom_range(3)), BYTE_W'($urandom), 1'($urandom));
         queue_ticks(n - split);
      end else begin
         queue_ticks(n);
      end
      well_formed_count += n + 1;
   endtask

   task automatic wait_drained();
      while (op_queue.size() != 0 || req_valid || expected_reports.size() != 0)
         @(negedge clock);
   endtask

   task automatic run_random(int target);
      int k;
      well_formed_count = 0;
      while (well_formed_count < target) begin
         k = $urandom_range(99);
         if (k < 85) queue_transaction();
         else if (k < 93) queue_ticks($urandom_range(1, 4));
         else queue_load(cmd_type'($urandom_range(3)), BYTE_W'($urandom), 1'($urandom));
      end
      wait_drained();
   endtask

   task automatic check_report();
      pin_report_type want;
      if (expected_reports.size() == 0) begin
         $error("response transfer with no prediction pending");
         error_count++;
         return;
      end
      want = expected_reports.pop_front();
      if (rsp_scl_level !== want.scl_level) begin
         $error("scl_level: expected %0d, got %0d", want.scl_level, rsp_scl_level);
         error_count++;
      end
      if (rsp_sda_level !== want.sda_level) begin
         $error("sda_level: expected %0d, got %0d", want.sda_level, rsp_sda_level);
         error_count++;
      end
      if (rsp_busy_res !== want.busy_res) begin
         $error("busy_res: expected %0d, got %0d", want.busy_res, rsp_busy_res);
         error_count++;
      end
      if (rsp_rx_byte !== want.rx_byte) begin
         $error("rx_byte: expected 0x%02h, got 0x%02h", want.rx_byte, rsp_rx_byte);
         error_count++;
      end
      if (rsp_ack_seen !== want.ack_seen) begin
         $error("ack_seen: expected %0d, got %0d", want.ack_seen, rsp_ack_seen);
         error_count++;
      end
      if (rsp_done_res !== want.done_res) begin
         $error("done_res: expected %0d, got %0d", want.done_res, rsp_done_res);
         error_count++;
      end
   endtask

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready)
            expected_reports.push_back(apply_bus_op(presented_op));
         if (!req_valid || req_ready) begin
            if (op_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               pick_op       = op_queue.pop_front();
               presented_op  = pick_op;
               req_action   <= pick_op.action;
               req_command  <= pick_op.command;
               req_tx_byte  <= pick_op.tx_byte;
               req_send_ack <= pick_op.send_ack;
               req_sda_line <= pick_op.sda_line;
               req_valid    <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // response monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready)
            check_report();
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   initial begin
      clear_pin_model();
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: idle tick, start with a command landing mid-sequence,
      // then a write of all ones
      queue_ticks(1);
      queue_load(CMD_START, 8'h00, 1'b0);
      queue_ticks(1);
      queue_load(CMD_STOP, 8'hff, 1'b1);
      queue_ticks(2);
      queue_load(CMD_WRITE, 8'hff, 1'b0);
      queue_ticks(19);
      queue_ticks(1);
      wait_drained();

      send_idle_pct = 38;
      recv_idle_pct = 71;
      run_random(ITEMS_PER_RUN);
      send_idle_pct = 71;
      recv_idle_pct = 38;
      run_random(ITEMS_PER_RUN);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      run_random(ITEMS_PER_RUN);

      repeat (10) @(negedge clock);
      if (error_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
